// ----- design/bbc_pkg.sv -----
// bbc_pkg: shared types, constants and character decode for the bracket balance checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package bbc_pkg;

   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int QUEUE_DEPTH         = 4;
   localparam int QUEUE_AW            = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;
   localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
   localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
   localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;
   localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
   localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;

   localparam logic [1:0] BR_ROUND  = 2'd0;
   localparam logic [1:0] BR_SQUARE = 2'd1;
   localparam logic [1:0] BR_CURLY  = 2'd2;

   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_MISMATCH = 3'd1;
   localparam logic [2:0] KIND_EMPTY    = 3'd2;
   localparam logic [2:0] KIND_OPEN     = 3'd3;
   localparam logic [2:0] KIND_OVERFLOW = 3'd4;

   typedef enum logic [1:0] {
      OP_SKIP,
      OP_OPEN,
      OP_CLOSE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] br;
      logic       last;
   } item_type;

   function automatic item_type classify(input logic [7:0] char_code, input logic is_last);
      item_type it;
      it.last = is_last;
      it.op   = OP_SKIP;
      it.br   = BR_ROUND;
      case (char_code)
         CHAR_OPEN_ROUND: begin
            it.op = OP_OPEN;
            it.br = BR_ROUND;
         end
         CHAR_OPEN_SQUARE: begin
            it.op = OP_OPEN;
            it.br = BR_SQUARE;
         end
         CHAR_OPEN_CURLY: begin
            it.op = OP_OPEN;
            it.br = BR_CURLY;
         end
         CHAR_CLOSE_ROUND: begin
            it.op = OP_CLOSE;
            it.br = BR_ROUND;
         end
         CHAR_CLOSE_SQUARE: begin
            it.op = OP_CLOSE;
            it.br = BR_SQUARE;
         end
         CHAR_CLOSE_CURLY: begin
            it.op = OP_CLOSE;
            it.br = BR_CURLY;
         end
         default: begin
            it.op = OP_SKIP;
            it.br = BR_ROUND;
         end
      endcase
      return it;
   endfunction

endpackage

// ----- design/bbc_front.sv -----
// bbc_front: accepts characters from the request stream and decodes them into queue items.
// Depends on bbc_pkg.
`timescale 1ns / 1ps
module bbc_front
   import bbc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // is_last
   input  logic       q_full,
   output logic       q_push,
   output item_type   q_item
);

   assign req_tready = ~q_full;
   assign q_push     = req_tvalid & ~q_full;
   assign q_item     = classify(req_tdata, req_tlast);

   property p_no_push_when_full;
      @(posedge clock) disable iff (reset) q_full |-> !q_push;
   endproperty
   a_no_push_when_full: assert property (p_no_push_when_full)
      else $error("push into full queue");

   property p_skip_has_round;
      @(posedge clock) disable iff (reset) (q_push && q_item.op == OP_SKIP) |-> q_item.br == BR_ROUND;
   endproperty
   a_skip_has_round: assert property (p_skip_has_round)
      else $error("skip item carries bracket type");

   property p_push_tracks_input;
      @(posedge clock) disable iff (reset) q_push |-> (req_tvalid && req_tready);
   endproperty
   a_push_tracks_input: assert property (p_push_tracks_input)
      else $error("queue push without transaction");

endmodule

// ----- design/bbc_queue.sv -----
// bbc_queue: short first-in first-out queue of decoded items between front and back.
// Depends on bbc_pkg.
`timescale 1ns / 1ps
module bbc_queue
   import bbc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     nonempty,
   output item_type pop_item
);

   item_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff, count_in;
   logic                    do_push, do_pop;

   assign full     = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign pop_item = entry_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & nonempty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   property p_count_bound;
      @(posedge clock) disable iff (reset) count_ff <= (QUEUE_AW + 1)'(QUEUE_DEPTH);
   endproperty
   a_count_bound: assert property (p_count_bound)
      else $error("queue count out of range");

   property p_ptr_gap;
      @(posedge clock) disable iff (reset)
         (count_ff != '0 && count_ff != (QUEUE_AW + 1)'(QUEUE_DEPTH))
            |-> wr_ptr_ff != rd_ptr_ff;
   endproperty
   a_ptr_gap: assert property (p_ptr_gap)
      else $error("queue pointers disagree with count");

   property p_push_counts;
      @(posedge clock) disable iff (reset) (do_push && !do_pop) |=> count_ff == $past(count_ff) + (QUEUE_AW + 1)'(1);
   endproperty
   a_push_counts: assert property (p_push_counts)
      else $error("queue count missed a push");

endmodule

// ----- design/bbc_back.sv -----
// bbc_back: executes queued items against the bracket stack and registers the verdict.
// Depends on bbc_pkg; holds the stack memory and the response output register.
`timescale 1ns / 1ps
module bbc_back
   import bbc_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_nonempty,
   input  item_type   q_item,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] balanced, [3:1] error_kind, [7:4] zero
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LW = $clog2(STACK_DEPTH + 1);

   logic [1:0]    stack_mem [STACK_DEPTH];
   logic [LW-1:0] level_ff, level_in;
   logic [1:0]    top_ff, top_in;
   logic [1:0]    second_ff;
   logic [2:0]    error_ff, error_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          balanced_ff, balanced_in;
   logic [2:0]    kind_ff, kind_in;

   logic          out_free, consume, active;
   logic          is_full, is_empty;
   logic          do_push, do_pop;
   logic [2:0]    err_new, verdict;
   logic [LW-1:0] level_step, level_dec, level_dec3;
   logic [AW-1:0] wr_addr, rd_addr;

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign consume    = q_nonempty & (~q_item.last | out_free);
   assign q_pop      = consume;
   assign active     = consume & (error_ff == KIND_NONE);
   assign is_full    = (level_ff == LW'(STACK_DEPTH));
   assign is_empty   = (level_ff == '0);
   assign level_dec  = level_ff - LW'(1);
   assign level_dec3 = level_ff - LW'(3);
   assign wr_addr    = level_dec[AW-1:0];
   assign rd_addr    = level_dec3[AW-1:0];

   always_comb begin
      do_push = 1'b0;
      do_pop  = 1'b0;
      err_new = error_ff;
      if (active) begin
         case (q_item.op)
            OP_OPEN: begin
               if (is_full) begin
                  err_new = KIND_OVERFLOW;
               end else begin
                  do_push = 1'b1;
               end
            end
            OP_CLOSE: begin
               if (is_empty) begin
                  err_new = KIND_EMPTY;
               end else if (top_ff == q_item.br) begin
                  do_pop = 1'b1;
               end else begin
                  err_new = KIND_MISMATCH;
               end
            end
            default: begin
               err_new = error_ff;
            end
         endcase
      end
   end

   always_comb begin
      level_step = level_ff;
      top_in     = top_ff;
      if (do_push) begin
         level_step = level_ff + LW'(1);
         top_in     = q_item.br;
      end else if (do_pop) begin
         level_step = level_dec;
         top_in     = second_ff;
      end
      if (err_new != KIND_NONE) begin
         verdict = err_new;
      end else if (level_step != '0) begin
         verdict = KIND_OPEN;
      end else begin
         verdict = KIND_NONE;
      end
      level_in     = level_step;
      error_in     = err_new;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      balanced_in  = balanced_ff;
      kind_in      = kind_ff;
      if (consume && q_item.last) begin
         level_in     = '0;
         error_in     = KIND_NONE;
         rsp_valid_in = 1'b1;
         balanced_in  = (verdict == KIND_NONE);
         kind_in      = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         error_ff     <= KIND_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      balanced_ff <= balanced_in;
      kind_ff     <= kind_in;
   end

   always_ff @(posedge clock) begin
      if (do_push && !is_empty) begin
         stack_mem[wr_addr] <= top_ff;
      end
      if (do_pop) begin
         second_ff <= stack_mem[rd_addr];
      end else if (do_push) begin
         second_ff <= top_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, kind_ff, balanced_ff};

   property p_level_bound;
      @(posedge clock) disable iff (reset) level_ff <= LW'(STACK_DEPTH);
   endproperty
   a_level_bound: assert property (p_level_bound)
      else $error("stack level beyond depth");

   property p_verdict_clears;
      @(posedge clock) disable iff (reset)
         (consume && q_item.last) |=> (level_ff == '0 && error_ff == KIND_NONE);
   endproperty
   a_verdict_clears: assert property (p_verdict_clears)
      else $error("state not cleared after verdict");

   property p_error_sticky;
      @(posedge clock) disable iff (reset)
         (error_ff != KIND_NONE && !(consume && q_item.last)) |=> $stable(error_ff);
   endproperty
   a_error_sticky: assert property (p_error_sticky)
      else $error("sticky error changed inside string");

   property p_no_stack_op_on_error;
      @(posedge clock) disable iff (reset)
         (error_ff != KIND_NONE) |-> (!do_push && !do_pop);
   endproperty
   a_no_stack_op_on_error: assert property (p_no_stack_op_on_error)
      else $error("stack moved after error");

   property p_balanced_kind;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff |-> (balanced_ff == (kind_ff == KIND_NONE));
   endproperty
   a_balanced_kind: assert property (p_balanced_kind)
      else $error("balanced flag disagrees with error kind");

endmodule

// ----- design/bracket_balance_checker.sv -----
// Bracket balance checker, one character per cycle while req_tready is high: every accepted
// character is decoded by the front end into a short queue, and the back end pushes or pops a
// bracket stack held as a top-of-stack register over a single-port memory, one operation per
// cycle while the queue holds items; the verdict for a string is registered in the response
// register when the back end takes its last character from the queue. Only the final character
// of a string (tlast) produces a response; a verdict held by rsp_tready stalls the next final
// character in the back end, and the four-entry queue then fills before req_tready drops.
// The stack needs no clearing pass after reset. Depends on bbc_pkg,
// bbc_front, bbc_queue and bbc_back.
`timescale 1ns / 1ps
module bracket_balance_checker
   import bbc_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // is_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] balanced, [3:1] error_kind, [7:4] zero
);

   logic     q_full, q_push, q_nonempty, q_pop;
   item_type q_in_item, q_out_item;

   bbc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_in_item)
   );

   bbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .nonempty  (q_nonempty),
      .pop_item  (q_out_item)
   );

   bbc_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_nonempty (q_nonempty),
      .q_item     (q_out_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
